>>> src/murmur3_32_stream_hash_top_macros.svh
// Assertion macros shared by the hash block's modules.
`ifndef MURMUR3_32_STREAM_HASH_TOP_MACROS_SVH
`define MURMUR3_32_STREAM_HASH_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define MM3_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("mm3 assertion failed");
`define MM3_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("mm3 assertion failed");
`else
`define MM3_ASSERT(label, prop)
`define MM3_ASSERT_ALWAYS(label, prop)
`endif

`endif

>>> src/mm3_pkg.sv
// Types and constants of the MurmurHash3 x86_32 stream hash.
package mm3_pkg;

    localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

    localparam logic [2:0] FULL_WORD = 3'd4;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // scrambled word on its way from front to back
    typedef struct packed {
        logic [31:0] k;
        logic [2:0]  count;
        logic        last;
    } mm3_entry_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } mm3_qstat_t;

endpackage

>>> src/mm3_front.sv
// Front end: accepts items, normalises the byte count, masks and scrambles the word.
`include "murmur3_32_stream_hash_top_macros.svh"

module mm3_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_data_word,
    input  logic [2:0]         s_byte_count,
    input  logic               s_last,
    input  mm3_pkg::mm3_qstat_t qstat,
    output logic               push,
    output mm3_pkg::mm3_entry_t push_entry
);

    logic        v1_reg, v1_next;
    logic        v2_reg, v2_next;
    logic [31:0] k1_reg, k1_next;
    logic [2:0]  c1_reg, c1_next;
    logic        l1_reg, l1_next;
    logic [31:0] k2_reg, k2_next;
    logic [2:0]  c2_reg, c2_next;
    logic        l2_reg, l2_next;

    logic        en;
    logic        s_accept;
    logic [2:0]  count;
    logic [31:0] mask;
    logic [31:0] k1_rot;

    assign push    = v2_reg && !qstat.full;
    assign en      = !v2_reg || !qstat.full;
    assign s_ready = en;
    assign s_accept = s_valid && en;

    always_comb begin
        if (s_byte_count > mm3_pkg::FULL_WORD ||
            (!s_last && s_byte_count < mm3_pkg::FULL_WORD)) begin
            count = mm3_pkg::FULL_WORD;
        end else begin
            count = s_byte_count;
        end
        case (count)
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            3'd3:    mask = 32'h00ff_ffff;
            3'd4:    mask = 32'hffff_ffff;
            default: mask = 32'h0000_0000;
        endcase
    end

    assign k1_rot = {k1_reg[16:0], k1_reg[31:17]};

    always_comb begin
        v1_next = v1_reg;
        v2_next = v2_reg;
        k1_next = k1_reg;
        c1_next = c1_reg;
        l1_next = l1_reg;
        k2_next = k2_reg;
        c2_next = c2_reg;
        l2_next = l2_reg;
        if (en) begin
            v1_next = s_accept;
            k1_next = (s_data_word & mask) * mm3_pkg::MIX_C1;
            c1_next = count;
            l1_next = s_last;
            v2_next = v1_reg;
            k2_next = k1_rot * mm3_pkg::MIX_C2;
            c2_next = c1_reg;
            l2_next = l1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        k1_reg <= k1_next;
        c1_reg <= c1_next;
        l1_reg <= l1_next;
        k2_reg <= k2_next;
        c2_reg <= c2_next;
        l2_reg <= l2_next;
    end

    assign push_entry.k     = k2_reg;
    assign push_entry.count = c2_reg;
    assign push_entry.last  = l2_reg;

    // a scrambled item waiting on a full queue must not be dropped
    `MM3_ASSERT(a_front_hold, v2_reg && !push |=> v2_reg)
    `MM3_ASSERT(a_front_stall, v2_reg && qstat.full |-> !s_ready)

endmodule

>>> src/mm3_queue.sv
// Four-entry queue between the scrambling front and the mixing back.
`include "murmur3_32_stream_hash_top_macros.svh"

module mm3_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  mm3_pkg::mm3_entry_t push_entry,
    input  logic                pop,
    output mm3_pkg::mm3_entry_t pop_entry,
    output mm3_pkg::mm3_qstat_t qstat
);

    mm3_pkg::mm3_entry_t slot_reg [mm3_pkg::QDEPTH];

    logic [mm3_pkg::QAW-1:0] wptr_reg, wptr_next;
    logic [mm3_pkg::QAW-1:0] rptr_reg, rptr_next;
    logic [mm3_pkg::QAW:0]   fill_reg, fill_next;

    assign qstat.full  = (fill_reg == (mm3_pkg::QAW+1)'(mm3_pkg::QDEPTH));
    assign qstat.empty = (fill_reg == '0);
    assign pop_entry   = slot_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (push) begin
            wptr_next = wptr_reg + 1'b1;
        end
        if (pop) begin
            rptr_next = rptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_entry;
        end
    end

    `MM3_ASSERT(a_q_no_overflow, !(push && qstat.full))
    `MM3_ASSERT(a_q_no_underflow, !(pop && qstat.empty))
    `MM3_ASSERT(a_q_fill_up, push && !pop |=> fill_reg == $past(fill_reg) + 1'b1)

endmodule

>>> src/mm3_back.sv
// Back end: mixes scrambled words into the running hash and finalises each message.
`include "murmur3_32_stream_hash_top_macros.svh"

module mm3_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [31:0]         seed,
    input  mm3_pkg::mm3_qstat_t qstat,
    input  mm3_pkg::mm3_entry_t pop_entry,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [31:0]         m_hash_value
);

    logic        in_msg_reg, in_msg_next;
    logic [31:0] hash_reg, hash_next;
    logic [31:0] total_reg, total_next;
    logic        f0_v_reg, f0_v_next;
    logic        f1_v_reg, f1_v_next;
    logic        f2_v_reg, f2_v_next;
    logic        out_v_reg, out_v_next;
    logic [31:0] f0_reg, f0_next;
    logic [31:0] f1_reg, f1_next;
    logic [31:0] f2_reg, f2_next;
    logic [31:0] out_reg, out_next;

    logic        en;
    logic [31:0] base;
    logic [31:0] hx;
    logic [31:0] hr;
    logic [31:0] mixed;
    logic [31:0] total_mix;

    assign en  = !out_v_reg || m_ready;
    assign pop = en && !qstat.empty;

    always_comb begin
        base      = in_msg_reg ? hash_reg : seed;
        hx        = base ^ pop_entry.k;
        hr        = {hx[18:0], hx[31:19]};
        mixed     = (pop_entry.count == mm3_pkg::FULL_WORD)
                  ? (hr << 2) + hr + mm3_pkg::MIX_ADD : hx;
        total_mix = (in_msg_reg ? total_reg : 32'd0) + {29'd0, pop_entry.count};
    end

    always_comb begin
        in_msg_next = in_msg_reg;
        hash_next   = hash_reg;
        total_next  = total_reg;
        f0_v_next   = f0_v_reg;
        f1_v_next   = f1_v_reg;
        f2_v_next   = f2_v_reg;
        out_v_next  = out_v_reg;
        f0_next     = f0_reg;
        f1_next     = f1_reg;
        f2_next     = f2_reg;
        out_next    = out_reg;
        if (pop) begin
            in_msg_next = !pop_entry.last;
            hash_next   = mixed;
            total_next  = total_mix;
        end
        if (en) begin
            f0_v_next  = pop && pop_entry.last;
            f0_next    = mixed ^ total_mix;
            f1_v_next  = f0_v_reg;
            f1_next    = (f0_reg ^ (f0_reg >> 16)) * mm3_pkg::FIN_M1;
            f2_v_next  = f1_v_reg;
            f2_next    = (f1_reg ^ (f1_reg >> 13)) * mm3_pkg::FIN_M2;
            out_v_next = f2_v_reg;
            out_next   = f2_reg ^ (f2_reg >> 16);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_msg_reg <= 1'b0;
            f0_v_reg   <= 1'b0;
            f1_v_reg   <= 1'b0;
            f2_v_reg   <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            in_msg_reg <= in_msg_next;
            f0_v_reg   <= f0_v_next;
            f1_v_reg   <= f1_v_next;
            f2_v_reg   <= f2_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        hash_reg  <= hash_next;
        total_reg <= total_next;
        f0_reg    <= f0_next;
        f1_reg    <= f1_next;
        f2_reg    <= f2_next;
        out_reg   <= out_next;
    end

    assign m_valid      = out_v_reg;
    assign m_hash_value = out_reg;

    // a last item closes the message and enters the finaliser
    `MM3_ASSERT(a_back_last, pop && pop_entry.last |=> !in_msg_reg && f0_v_reg)

endmodule

>>> src/murmur3_32_stream_hash_top.sv
// Top level of the MurmurHash3 x86_32 stream hash.
//
//  channel  | ports                                   | role
//  ---------+-----------------------------------------+---------------------------
//  s_       | s_valid s_ready s_data_word s_byte_count | word items of a message
//           | s_last                                  |
//  m_       | m_valid m_ready m_hash_value            | one hash per message
//  cfg_     | cfg_valid cfg_ready cfg_data            | seed register write
//
// One item per cycle is taken while the queue has room; the running-hash loop
// in the back end (xor, rotate, times five plus constant) closes through the
// hash register. The hash shows on m_valid once the last item has passed,
// in order, two scramble multiplier stages, the queue slot, the mix, two
// finaliser multiplier stages and the output register. Reset is synchronous
// and clears all valid state and the seed. A stalled result holds the back
// end; the four-entry queue lets the front keep taking items until it fills.
module murmur3_32_stream_hash_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic [31:0] seed_reg, seed_next;

    mm3_pkg::mm3_qstat_t qstat;
    mm3_pkg::mm3_entry_t push_entry;
    mm3_pkg::mm3_entry_t pop_entry;
    logic                push;
    logic                pop;

    assign cfg_ready = 1'b1;
    assign seed_next = (cfg_valid && cfg_ready) ? cfg_data : seed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= 32'd0;
        end else begin
            seed_reg <= seed_next;
        end
    end

    mm3_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_word  (s_data_word),
        .s_byte_count (s_byte_count),
        .s_last       (s_last),
        .qstat        (qstat),
        .push         (push),
        .push_entry   (push_entry)
    );

    mm3_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .qstat      (qstat)
    );

    mm3_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .seed         (seed_reg),
        .qstat        (qstat),
        .pop_entry    (pop_entry),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

endmodule
